// ===== hw/rtl/dfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg
// Types, permutation tables and S-box contents for the DES round datapath.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int unsigned HalfW  = 32;
  localparam int unsigned KeyW   = 28;
  localparam int unsigned SubW   = 48;
  localparam int unsigned NumBox = 8;

  typedef struct packed {
    logic [HalfW-1:0] left_half;
    logic [HalfW-1:0] right_half;
    logic [KeyW-1:0]  key_c_in;
    logic [KeyW-1:0]  key_d_in;
  } dfr_req_t;

  typedef struct packed {
    logic [HalfW-1:0] new_left;
    logic [HalfW-1:0] new_right;
    logic [KeyW-1:0]  key_c_out;
    logic [KeyW-1:0]  key_d_out;
  } dfr_rsp_t;

  // tables use the standard numbering: entry 1 is the most significant bit
  localparam logic [5:0] PC2_TAB [SubW] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [5:0] E_TAB [SubW] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [HalfW] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SBOX_TAB [NumBox][64] = '{
    '{ 4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
       4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
       4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
       4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13 },
    '{ 4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
       4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
       4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
       4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9 },
    '{ 4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
       4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
       4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
       4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12 },
    '{ 4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
       4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
       4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
       4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14 },
    '{ 4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
       4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
       4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
       4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3 },
    '{ 4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
       4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
       4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
       4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13 },
    '{ 4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
       4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
       4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
       4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12 },
    '{ 4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
       4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
       4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
       4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11 }
  };

  function automatic logic [SubW-1:0] dfr_pc2(input logic [2*KeyW-1:0] cd);
    logic [SubW-1:0] res;
    logic [5:0]      idx;
    res = '0;
    for (int i = 0; i < SubW; i++) begin
      idx = 6'(2*KeyW) - PC2_TAB[i];
      res[SubW-1-i] = cd[idx];
    end
    return res;
  endfunction

  function automatic logic [SubW-1:0] dfr_expand(input logic [HalfW-1:0] r);
    logic [SubW-1:0] res;
    logic [5:0]      pos;
    res = '0;
    for (int i = 0; i < SubW; i++) begin
      pos = 6'(HalfW) - E_TAB[i];
      res[SubW-1-i] = r[pos[4:0]];
    end
    return res;
  endfunction

  function automatic logic [HalfW-1:0] dfr_perm_p(input logic [HalfW-1:0] s);
    logic [HalfW-1:0] res;
    logic [5:0]       pos;
    res = '0;
    for (int i = 0; i < HalfW; i++) begin
      pos = 6'(HalfW) - P_TAB[i];
      res[HalfW-1-i] = s[pos[4:0]];
    end
    return res;
  endfunction

  // row comes from the outer bits of each six-bit group, column from the inner four
  function automatic logic [HalfW-1:0] dfr_sbox(input logic [SubW-1:0] x);
    logic [HalfW-1:0] res;
    logic [5:0]       six;
    res = '0;
    for (int i = 0; i < NumBox; i++) begin
      six = x[SubW-1-6*i -: 6];
      res[HalfW-1-4*i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dfr_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_in_if
// Request channel of the DES round: both data halves and both key halves.
// ----------------------------------------------------------------------------
interface dfr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_half;
  logic [31:0] right_half;
  logic [27:0] key_c_in;
  logic [27:0] key_d_in;

  modport source (
    output valid, left_half, right_half, key_c_in, key_d_in,
    input  ready
  );
  modport sink (
    input  valid, left_half, right_half, key_c_in, key_d_in,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/dfr_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_out_if
// Result channel of the DES round: swapped halves and rotated key halves.
// ----------------------------------------------------------------------------
interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_left;
  logic [31:0] new_right;
  logic [27:0] key_c_out;
  logic [27:0] key_d_out;

  modport source (
    output valid, new_left, new_right, key_c_out, key_d_out,
    input  ready
  );
  modport sink (
    input  valid, new_left, new_right, key_c_out, key_d_out,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/dfr_round_fn.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_round_fn
// Combinational round datapath: key rotation, PC-2, E, S-boxes, P and swap.
// ----------------------------------------------------------------------------
module dfr_round_fn (
  input  dfr_pkg::dfr_req_t req_i,
  output dfr_pkg::dfr_rsp_t rsp_o
);

  logic [dfr_pkg::KeyW-1:0]   key_c;
  logic [dfr_pkg::KeyW-1:0]   key_d;
  logic [dfr_pkg::SubW-1:0]   subkey;
  logic [dfr_pkg::SubW-1:0]   mixed;
  logic [dfr_pkg::HalfW-1:0]  f_val;

  assign key_c  = {req_i.key_c_in[dfr_pkg::KeyW-2:0], req_i.key_c_in[dfr_pkg::KeyW-1]};
  assign key_d  = {req_i.key_d_in[dfr_pkg::KeyW-2:0], req_i.key_d_in[dfr_pkg::KeyW-1]};
  assign subkey = dfr_pkg::dfr_pc2({key_c, key_d});
  assign mixed  = dfr_pkg::dfr_expand(req_i.right_half) ^ subkey;
  assign f_val  = dfr_pkg::dfr_perm_p(dfr_pkg::dfr_sbox(mixed));

  assign rsp_o.new_left  = req_i.right_half;
  assign rsp_o.new_right = req_i.left_half ^ f_val;
  assign rsp_o.key_c_out = key_c;
  assign rsp_o.key_d_out = key_d;

endmodule
`default_nettype wire

// ===== hw/rtl/des_feistel_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// des_feistel_round
// One DES round with subkey derivation, between an input and a result register.
//
//   channel  dir  payload
//   req_i    in   left_half, right_half, key_c_in, key_d_in
//   rsp_o    out  new_left, new_right, key_c_out, key_d_out
//
// one request per cycle while the result side is not stalled; the round logic
// sits between the input register and the result register
// a stalled result holds both registers; the request side stays open while
// either register is free or is emptied in the same cycle
// reset empties both stages, payload registers are not reset
// ----------------------------------------------------------------------------
module des_feistel_round (
  input  wire           clk_i,
  input  wire           rst_ni,
  dfr_in_if.sink        req_i,
  dfr_out_if.source     rsp_o
);

  logic              in_valid_q;
  dfr_pkg::dfr_req_t in_q;
  logic              out_valid_q;
  dfr_pkg::dfr_rsp_t out_q;
  dfr_pkg::dfr_rsp_t out_d;
  logic              out_free;
  logic              in_free;
  logic              req_take;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign in_free  = !in_valid_q || out_free;
  assign req_take = req_i.valid && in_free;

  assign req_i.ready = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_q.left_half  <= req_i.left_half;
      in_q.right_half <= req_i.right_half;
      in_q.key_c_in   <= req_i.key_c_in;
      in_q.key_d_in   <= req_i.key_d_in;
    end
    if (out_free && in_valid_q) begin
      out_q <= out_d;
    end
  end

  dfr_round_fn u_round_fn (
    .req_i (in_q),
    .rsp_o (out_d)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.new_left  = out_q.new_left;
  assign rsp_o.new_right = out_q.new_right;
  assign rsp_o.key_c_out = out_q.key_c_out;
  assign rsp_o.key_d_out = out_q.key_d_out;

  // a taken request always lands in the input stage
  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> in_valid_q)
    else $error("accepted request did not enter the input stage");

  // back-pressure only when both stages hold data
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> in_valid_q && out_valid_q && !rsp_o.ready)
    else $error("request side closed with a free stage");

  // a stage that moves forward hands its right half on as the new left half
  a_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> rsp_o.valid && rsp_o.new_left == $past(in_q.right_half))
    else $error("result stage lost the swapped half");

endmodule
`default_nettype wire
